FILE: rtl/pftv_pkg.sv
// Shared types and constants of the pixel flash, tint and vignette pipeline.
// Used by every module under rtl/. No dependencies.
package pftv_pkg;

  // Field and datapath widths
  localparam int unsigned MAX_WIDTH   = 4096;
  localparam int unsigned MAX_HEIGHT  = 4096;
  localparam int unsigned DIM_W       = 13;   // frame size register
  localparam int unsigned COORD_W     = 12;   // pixel column / row
  localparam int unsigned CH_W        = 8;    // one color channel
  localparam int unsigned DIFF_W      = 14;   // doubled coordinate minus size, signed
  localparam int unsigned SQ_W        = 26;   // one squared offset
  localparam int unsigned DIST_W      = 27;   // sum of squared offsets
  localparam int unsigned NORM_W      = 26;   // w*w + h*h
  localparam int unsigned FRAC_W      = 16;
  localparam int unsigned FACT_W      = FRAC_W + 1;   // factor up to 1.0
  localparam int unsigned ADD_W       = CH_W + FRAC_W; // 255 * t
  localparam int unsigned PROD_W      = CH_W + FACT_W;
  localparam int unsigned ROOT_W      = 16;
  localparam int unsigned SREM_W      = ROOT_W + 1;
  localparam int unsigned DIV_STAGES  = 16;   // two quotient bits per stage
  localparam int unsigned ROOT_STAGES = DIV_STAGES + 1;
  localparam int unsigned RECIP_W     = 18;
  localparam int unsigned RECIP_SHIFT = 18;
  localparam int unsigned SCALE_W     = ROOT_W + RECIP_W;

  // Fixed point constants
  localparam logic [FACT_W-1:0]  ONE_Q16    = 17'h10000;
  localparam logic [FACT_W-1:0]  V_FLOOR    = 17'h08000;  // vignette never below 0.5
  localparam logic [4:0]         FLASH_CAP  = 5'd20;
  localparam logic [11:0]        FLASH_STEP = 12'd2313;   // 3*2^16/85, exact up to 20 steps
  localparam logic [FACT_W-1:0]  RED_T_H1   = 17'd14745;  // (1-1/4)*0.3
  localparam logic [FACT_W-1:0]  RED_T_H2   = 17'd9830;   // (1-2/4)*0.3
  localparam logic [RECIP_W-1:0] RECIP_3_5  = 18'd157287; // 3 * (2^18+1)/5

  // Reset values of the registers and what follows from them
  localparam logic [DIM_W-1:0]  RST_FRAME  = 13'd256;
  localparam logic [4:0]        RST_FLASH  = 5'd0;
  localparam logic [3:0]        RST_HEALTH = 4'd4;
  localparam logic [NORM_W-1:0] RST_DIM_SQ = 26'd65536;
  localparam logic [NORM_W-1:0] RST_NORM   = 26'd131072;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_FLASH_LEVEL  = 2'd2,
    CFG_HEALTH_LEVEL = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pix_t;

  // Settings as the datapath sees them
  typedef struct packed {
    logic [DIM_W-1:0]  width;    // clamped
    logic [DIM_W-1:0]  height;   // clamped
    logic [NORM_W-1:0] norm;     // width^2 + height^2
    logic [FACT_W-1:0] keep;     // 1 - t
    logic [ADD_W-1:0]  add_red;  // 255*t when any blend
    logic [ADD_W-1:0]  add_gb;   // 255*t for white only
    logic              bypass;   // zero health: pixel passes untouched
  } cfg_t;

  // One stage of the ratio / root pipeline
  typedef struct packed {
    logic [NORM_W-1:0] rem;   // division remainder
    logic [1:0]        pair;  // quotient bits made in this stage
    logic [ROOT_W-1:0] root;
    logic [SREM_W-1:0] srem;  // root remainder
    logic              sat;   // distance at or past the frame corner
    pix_t              pix;
  } rr_stage_t;

endpackage

FILE: rtl/pftv_cfg.sv
// Configuration registers and the settings derived from them.
// Depends on pftv_pkg.
module pftv_cfg import pftv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [DIM_W-1:0] cfg_data_i,
  output cfg_t             cfg_o
);

  logic [DIM_W-1:0]  width_q, height_q;
  logic [4:0]        flash_q;
  logic [3:0]        health_q;
  logic [DIM_W-1:0]  w_cl, h_cl;
  logic [4:0]        flash_eff;
  logic [FACT_W-1:0] t_flash, t;
  logic              white;
  logic [PROD_W-1:0] add_full;
  logic [NORM_W-1:0] wsq_d, wsq_q, hsq_d, hsq_q, norm_d, norm_q;
  logic [FACT_W-1:0] keep_d, keep_q;
  logic [ADD_W-1:0]  add_red_d, add_red_q, add_gb_d, add_gb_q;
  logic              bypass_d, bypass_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_FRAME;
      height_q <= RST_FRAME;
      flash_q  <= RST_FLASH;
      health_q <= RST_HEALTH;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        CFG_FLASH_LEVEL:  flash_q  <= cfg_data_i[4:0];
        CFG_HEALTH_LEVEL: health_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  // clamp frame size to 1..max
  always_comb begin
    if (width_q == '0)                    w_cl = DIM_W'(1);
    else if (width_q > DIM_W'(MAX_WIDTH)) w_cl = DIM_W'(MAX_WIDTH);
    else                                  w_cl = width_q;
    if (height_q == '0)                     h_cl = DIM_W'(1);
    else if (height_q > DIM_W'(MAX_HEIGHT)) h_cl = DIM_W'(MAX_HEIGHT);
    else                                    h_cl = height_q;
  end

  assign flash_eff = (flash_q > FLASH_CAP) ? FLASH_CAP : flash_q;
  assign t_flash   = FACT_W'(FACT_W'(flash_eff) * FACT_W'(FLASH_STEP));

  // blend selection: zero health bypasses; otherwise flash wins over low-health tint
  always_comb begin
    bypass_d = 1'b0;
    white    = 1'b0;
    t        = '0;
    if (health_q == '0) begin
      bypass_d = 1'b1;
    end else if (flash_q != '0) begin
      t     = t_flash;
      white = 1'b1;
    end else begin
      case (health_q)
        4'd1:    t = RED_T_H1;
        4'd2:    t = RED_T_H2;
        default: t = '0;
      endcase
    end
  end

  assign add_full  = {t, 8'h00} - PROD_W'(t);
  assign add_red_d = add_full[ADD_W-1:0];
  assign add_gb_d  = white ? add_full[ADD_W-1:0] : '0;
  assign keep_d    = ONE_Q16 - t;
  assign wsq_d     = NORM_W'(w_cl) * NORM_W'(w_cl);
  assign hsq_d     = NORM_W'(h_cl) * NORM_W'(h_cl);
  assign norm_d    = wsq_q + hsq_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wsq_q     <= RST_DIM_SQ;
      hsq_q     <= RST_DIM_SQ;
      norm_q    <= RST_NORM;
      keep_q    <= ONE_Q16;
      add_red_q <= '0;
      add_gb_q  <= '0;
      bypass_q  <= 1'b0;
    end else begin
      wsq_q     <= wsq_d;
      hsq_q     <= hsq_d;
      norm_q    <= norm_d;
      keep_q    <= keep_d;
      add_red_q <= add_red_d;
      add_gb_q  <= add_gb_d;
      bypass_q  <= bypass_d;
    end
  end

  assign cfg_o.width   = w_cl;
  assign cfg_o.height  = h_cl;
  assign cfg_o.norm    = norm_q;
  assign cfg_o.keep    = keep_q;
  assign cfg_o.add_red = add_red_q;
  assign cfg_o.add_gb  = add_gb_q;
  assign cfg_o.bypass  = bypass_q;

endmodule

FILE: rtl/pftv_front.sv
// Front stages: centre offsets, squared distance and the color blend.
// Depends on pftv_pkg.
module pftv_front import pftv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  logic [COORD_W-1:0] pixel_x_i,
  input  logic [COORD_W-1:0] pixel_y_i,
  input  pix_t               pix_i,
  input  cfg_t               cfg_i,
  output logic               valid_o,
  output logic [DIST_W-1:0]  dist_o,
  output pix_t               pix_o
);

  logic [2:0] v_q;

  // stage 1
  logic signed [DIFF_W-1:0] dx_d, dy_d, dx_q, dy_q;
  pix_t                     pix1_q;
  // stage 2
  logic signed [2*DIFF_W-1:0] sqx, sqy;
  logic [SQ_W-1:0]            dx2_q, dy2_q;
  logic [PROD_W-1:0]          pr_r_d, pr_g_d, pr_b_d, pr_r_q, pr_g_q, pr_b_q;
  // stage 3
  logic [PROD_W-1:0] sum_r, sum_g, sum_b;
  logic [DIST_W-1:0] dist_d, dist_q;
  pix_t              pix3_d, pix3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // doubled coordinates: 2x - w
  assign dx_d = $signed({1'b0, pixel_x_i, 1'b0}) - $signed({1'b0, cfg_i.width});
  assign dy_d = $signed({1'b0, pixel_y_i, 1'b0}) - $signed({1'b0, cfg_i.height});

  assign sqx    = (2*DIFF_W)'(dx_q) * (2*DIFF_W)'(dx_q);
  assign sqy    = (2*DIFF_W)'(dy_q) * (2*DIFF_W)'(dy_q);
  assign pr_r_d = PROD_W'(pix1_q.red)   * PROD_W'(cfg_i.keep);
  assign pr_g_d = PROD_W'(pix1_q.green) * PROD_W'(cfg_i.keep);
  assign pr_b_d = PROD_W'(pix1_q.blue)  * PROD_W'(cfg_i.keep);

  assign sum_r        = pr_r_q + PROD_W'(cfg_i.add_red);
  assign sum_g        = pr_g_q + PROD_W'(cfg_i.add_gb);
  assign sum_b        = pr_b_q + PROD_W'(cfg_i.add_gb);
  assign pix3_d.red   = sum_r[FRAC_W +: CH_W];
  assign pix3_d.green = sum_g[FRAC_W +: CH_W];
  assign pix3_d.blue  = sum_b[FRAC_W +: CH_W];
  assign dist_d       = DIST_W'(dx2_q) + DIST_W'(dy2_q);

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      pix1_q <= pix_i;
      dx2_q  <= sqx[SQ_W-1:0];
      dy2_q  <= sqy[SQ_W-1:0];
      pr_r_q <= pr_r_d;
      pr_g_q <= pr_g_d;
      pr_b_q <= pr_b_d;
      dist_q <= dist_d;
      pix3_q <= pix3_d;
    end
  end

  assign valid_o = v_q[2];
  assign dist_o  = dist_q;
  assign pix_o   = pix3_q;

endmodule

FILE: rtl/pftv_ratio_root.sv
// Pipelined radix-4 divider feeding a digit-by-digit square root:
// root = isqrt(dist * 2^32 / norm). Depends on pftv_pkg.
module pftv_ratio_root import pftv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [DIST_W-1:0] dist_i,
  input  logic [NORM_W-1:0] norm_i,
  input  pix_t              pix_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output logic              sat_o,
  output pix_t              pix_o
);

  logic [ROOT_STAGES-1:0] v_q;
  rr_stage_t              st_d [ROOT_STAGES];
  rr_stage_t              st_q [ROOT_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[ROOT_STAGES-2:0], valid_i};
    end
  end

  // Stage j makes quotient bits 2j, 2j+1 and runs the root step on the
  // pair made by stage j-1, so the root trails the quotient by one stage.
  always_comb begin
    rr_stage_t         prv;
    logic [NORM_W:0]   t1, t2;
    logic [NORM_W-1:0] r1;
    logic              b1, b0;
    logic [SREM_W+1:0] sr, trial;
    for (int j = 0; j < ROOT_STAGES; j++) begin
      t1    = '0;
      t2    = '0;
      r1    = '0;
      b1    = 1'b0;
      b0    = 1'b0;
      sr    = '0;
      trial = '0;
      if (j == 0) begin
        prv     = '0;
        prv.rem = dist_i[NORM_W-1:0];
        prv.sat = (dist_i >= DIST_W'(norm_i));
        prv.pix = pix_i;
      end else begin
        prv = st_q[j-1];
      end
      st_d[j] = prv;

      if (j < DIV_STAGES) begin
        t1 = {prv.rem, 1'b0};
        b1 = (t1 >= {1'b0, norm_i});
        r1 = b1 ? NORM_W'(t1 - {1'b0, norm_i}) : t1[NORM_W-1:0];
        t2 = {r1, 1'b0};
        b0 = (t2 >= {1'b0, norm_i});
        st_d[j].rem  = b0 ? NORM_W'(t2 - {1'b0, norm_i}) : t2[NORM_W-1:0];
        st_d[j].pair = {b1, b0};
      end else begin
        st_d[j].rem  = '0;
        st_d[j].pair = '0;
      end

      if (j > 0) begin
        sr    = {prv.srem, prv.pair};
        trial = {1'b0, prv.root, 2'b01};
        if (sr >= trial) begin
          st_d[j].srem = SREM_W'(sr - trial);
          st_d[j].root = {prv.root[ROOT_W-2:0], 1'b1};
        end else begin
          st_d[j].srem = sr[SREM_W-1:0];
          st_d[j].root = {prv.root[ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_q <= st_d;
    end
  end

  assign valid_o = v_q[ROOT_STAGES-1];
  assign root_o  = st_q[ROOT_STAGES-1].root;
  assign sat_o   = st_q[ROOT_STAGES-1].sat;
  assign pix_o   = st_q[ROOT_STAGES-1].pix;

endmodule

FILE: rtl/pftv_shade.sv
// Vignette factor from the distance ratio and the final channel scaling;
// the last stage is the output register. Depends on pftv_pkg.
module pftv_shade import pftv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic              sat_i,
  input  pix_t              pix_i,
  input  logic              bypass_i,
  output logic              valid_o,
  output pix_t              pix_o
);

  logic [2:0]         v_q;
  logic [SCALE_W-1:0] scale_d, scale_q;
  logic               sat1_q;
  pix_t               pix1_q, pix2_q, pix3_d, pix3_q;
  logic [ROOT_W-1:0]  s;
  logic [FACT_W-1:0]  vig_d, vig_q;
  logic [PROD_W-1:0]  o_r, o_g, o_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // s = floor(3*root/5) by reciprocal multiply, exact for 3*root < 2^18
  assign scale_d = SCALE_W'(root_i) * SCALE_W'(RECIP_3_5);
  assign s       = scale_q[RECIP_SHIFT +: ROOT_W];

  always_comb begin
    if (bypass_i)                           vig_d = ONE_Q16;
    else if (sat1_q || s >= ROOT_W'(V_FLOOR)) vig_d = V_FLOOR;
    else                                    vig_d = ONE_Q16 - FACT_W'(s);
  end

  assign o_r          = PROD_W'(pix2_q.red)   * PROD_W'(vig_q);
  assign o_g          = PROD_W'(pix2_q.green) * PROD_W'(vig_q);
  assign o_b          = PROD_W'(pix2_q.blue)  * PROD_W'(vig_q);
  assign pix3_d.red   = o_r[FRAC_W +: CH_W];
  assign pix3_d.green = o_g[FRAC_W +: CH_W];
  assign pix3_d.blue  = o_b[FRAC_W +: CH_W];

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      scale_q <= scale_d;
      sat1_q  <= sat_i;
      pix1_q  <= pix_i;
      vig_q   <= vig_d;
      pix2_q  <= pix1_q;
      pix3_q  <= pix3_d;
    end
  end

  assign valid_o = v_q[2];
  assign pix_o   = pix3_q;

endmodule

FILE: rtl/pixel_flash_tint_vignette_top.sv
// Pixel flash / low-health tint / radial vignette post-process.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per pixel: column,
//   row and RGB. An item is taken on a rising edge with valid high and stall
//   low. Output channel (out_valid_o / out_stall_i) delivers one item per
//   input item, in order.
//   Config channel (cfg_valid_i / cfg_ready_o, always ready) writes frame
//   width (0), frame height (1), flash level (2) and health level (3); write
//   only while no items are in flight.
//   Depth: 23 register stages (3 front, 17 divide/root, 3 shading).
//   Throughput: one item every cycle while the output is not stalled; the
//   depth is set by the radix-4 divide of squared distance by the squared
//   frame diagonal, which runs interleaved with a square root, one stage per
//   digit.
//   Stall: the whole pipeline holds while the output item waits; in_stall_o
//   follows out_stall_i whenever the output register is full.
//   Reset: clears all valid bits and loads 256x256 frame, flash 0, health 4.
// Depends on pftv_pkg, pftv_cfg, pftv_front, pftv_ratio_root, pftv_shade.
module pixel_flash_tint_vignette_top import pftv_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel in
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [COORD_W-1:0] pixel_x_i,
  input  logic [COORD_W-1:0] pixel_y_i,
  input  logic [CH_W-1:0]    red_in_i,
  input  logic [CH_W-1:0]    green_in_i,
  input  logic [CH_W-1:0]    blue_in_i,
  // pixel out
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [CH_W-1:0]    red_out_o,
  output logic [CH_W-1:0]    green_out_o,
  output logic [CH_W-1:0]    blue_out_o,
  // register writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [DIM_W-1:0]   cfg_data_i
);

  logic              adv;
  cfg_t              cfg;
  pix_t              pix_in, pix_fr, pix_rr, pix_out;
  logic              v_fr, v_rr, v_out;
  logic [DIST_W-1:0] dist_sq;
  logic [ROOT_W-1:0] root;
  logic              sat;

  // the pipeline moves as a whole unless the output item is held
  assign adv        = !(v_out && out_stall_i);
  assign in_stall_o = !adv;

  assign pix_in.red   = red_in_i;
  assign pix_in.green = green_in_i;
  assign pix_in.blue  = blue_in_i;

  pftv_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // offsets from centre, squared distance, color blend
  pftv_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .valid_i   (in_valid_i),
    .pixel_x_i (pixel_x_i),
    .pixel_y_i (pixel_y_i),
    .pix_i     (pix_in),
    .cfg_i     (cfg),
    .valid_o   (v_fr),
    .dist_o    (dist_sq),
    .pix_o     (pix_fr)
  );

  // distance ratio to the corner, as a square root with 16 fraction bits
  pftv_ratio_root u_ratio_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (v_fr),
    .dist_i  (dist_sq),
    .norm_i  (cfg.norm),
    .pix_i   (pix_fr),
    .valid_o (v_rr),
    .root_o  (root),
    .sat_o   (sat),
    .pix_o   (pix_rr)
  );

  // vignette factor and channel scaling into the output register
  pftv_shade u_shade (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .valid_i  (v_rr),
    .root_i   (root),
    .sat_i    (sat),
    .pix_i    (pix_rr),
    .bypass_i (cfg.bypass),
    .valid_o  (v_out),
    .pix_o    (pix_out)
  );

  assign out_valid_o = v_out;
  assign red_out_o   = pix_out.red;
  assign green_out_o = pix_out.green;
  assign blue_out_o  = pix_out.blue;

endmodule

FILE: tb/tb_pixel_flash_tint_vignette_top.sv
// Testbench for the pixel flash / tint / vignette post-process.
// Predicts every output pixel in place and checks the stream in order; depends
// on pftv_pkg and pixel_flash_tint_vignette_top.
`timescale 1ns / 1ps

module tb_pixel_flash_tint_vignette_top;
  import pftv_pkg::*;

  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int unsigned TAIL_CYCLES = 40;    // beyond the pipeline latency

  // receiver stall patterns
  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_BURSTY = 2;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] pixel_x = '0;
  logic [COORD_W-1:0] pixel_y = '0;
  logic [CH_W-1:0]    red_in = '0;
  logic [CH_W-1:0]    green_in = '0;
  logic [CH_W-1:0]    blue_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [CH_W-1:0]    red_out;
  logic [CH_W-1:0]    green_out;
  logic [CH_W-1:0]    blue_out;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [DIM_W-1:0]   cfg_data = '0;

  // Register mirror, as written (clamping happens in the predictor)
  logic [DIM_W-1:0] cur_width  = RST_FRAME;
  logic [DIM_W-1:0] cur_height = RST_FRAME;
  logic [4:0]       cur_flash  = RST_FLASH;
  logic [3:0]       cur_health = RST_HEALTH;

  pix_t expected_pixels[$];
  int   mismatch_count = 0;

  // Receiver control, written only by the test sequence
  int stall_mode = STALL_NONE;
  int hold_seq   = 0;

  pixel_flash_tint_vignette_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .pixel_x_i   (pixel_x),
    .pixel_y_i   (pixel_y),
    .red_in_i    (red_in),
    .green_in_i  (green_in),
    .blue_in_i   (blue_in),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .red_out_o   (red_out),
    .green_out_o (green_out),
    .blue_out_o  (blue_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned dim_clamp(input logic [DIM_W-1:0] v, input int unsigned hi);
    if (v == 0) return 1;
    if (32'(v) > hi) return hi;
    return 32'(v);
  endfunction

  // largest r with r*r <= n, bit by bit from the top
  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] root;
    logic [63:0] probe;
    root = '0;
    for (int k = 31; k >= 0; k--) begin
      probe = root | (64'd1 << k);
      if (probe * probe <= n) root = probe;
    end
    return root;
  endfunction

  function automatic int unsigned blend_toward(input int unsigned c, input int unsigned target,
                                               input int unsigned t);
    return (c * (32'd65536 - t) + target * t) >> 16;
  endfunction

  function automatic pix_t predict_shaded_pixel(input logic [COORD_W-1:0] px,
                                                input logic [COORD_W-1:0] py,
                                                input logic [CH_W-1:0] r,
                                                input logic [CH_W-1:0] g,
                                                input logic [CH_W-1:0] b);
    int unsigned ch [3];
    int unsigned w, h, f, t;
    longint      xs, ys, dx, dy;
    logic [63:0] d2, m2, ratio, root, s, v;
    pix_t        res;
    ch[0] = 32'(r);
    ch[1] = 32'(g);
    ch[2] = 32'(b);
    // zero health bypasses everything
    if (cur_health != 0) begin
      w = dim_clamp(cur_width, MAX_WIDTH);
      h = dim_clamp(cur_height, MAX_HEIGHT);
      if (cur_flash != 0) begin
        f = 32'((cur_flash > FLASH_CAP) ? FLASH_CAP : cur_flash);
        t = (f * 3 * 65536) / 85;
        for (int i = 0; i < 3; i++) ch[i] = blend_toward(ch[i], 255, t);
      end else if (cur_health <= 2) begin
        t = ((4 - 32'(cur_health)) * 3 * 65536) / 40;
        ch[0] = blend_toward(ch[0], 255, t);
        ch[1] = blend_toward(ch[1], 0, t);
        ch[2] = blend_toward(ch[2], 0, t);
      end
      // doubled coordinates relative to the frame centre
      xs = longint'(px);
      ys = longint'(py);
      dx = 2 * xs - longint'(w);
      dy = 2 * ys - longint'(h);
      d2 = dx * dx + dy * dy;
      m2 = 64'(w) * 64'(w) + 64'(h) * 64'(h);
      ratio = (d2 << 32) / m2;
      root = int_sqrt(ratio);
      s = (root * 64'd3) / 64'd5;
      v = (s >= 64'd32768) ? 64'd32768 : 64'd65536 - s;
      for (int i = 0; i < 3; i++) ch[i] = 32'((64'(ch[i]) * v) >> 16);
    end
    res.red   = ch[0][CH_W-1:0];
    res.green = ch[1][CH_W-1:0];
    res.blue  = ch[2][CH_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: stall patterns plus a counted long hold-off
  // ---------------------------------------------------------------------------

  int   hold_seen = 0;
  int   hold_left = 0;
  int   stall_run = 0;
  logic stall_level = 1'b0;

  always @(posedge clk) begin
    if (hold_seen != hold_seq) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: begin
          out_stall <= ($urandom_range(0, 99) < 30);
        end
        STALL_BURSTY: begin
          if (stall_run == 0) begin
            stall_level = ~stall_level;
            stall_run = stall_level ? $urandom_range(1, 6) : $urandom_range(1, 12);
          end
          stall_run--;
          out_stall <= stall_level;
        end
        default: begin
          out_stall <= 1'b0;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Output checker: every accepted output item against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_pixels
    pix_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        if (mismatch_count < 10)
          $display("%0t: output item with nothing pending: r=%0d g=%0d b=%0d",
                   $realtime, red_out, green_out, blue_out);
        mismatch_count++;
      end else begin
        want = expected_pixels.pop_front();
        if (red_out !== want.red || green_out !== want.green || blue_out !== want.blue) begin
          if (mismatch_count < 10)
            $display("%0t: pixel mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                     $realtime, want.red, want.green, want.blue,
                     red_out, green_out, blue_out);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offer one item and hold it until accepted; valid stays high afterwards.
  task automatic send_pixel(input logic [COORD_W-1:0] px, input logic [COORD_W-1:0] py,
                            input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    in_valid <= 1'b1;
    pixel_x  <= px;
    pixel_y  <= py;
    red_in   <= r;
    green_in <= g;
    blue_in  <= b;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(predict_shaded_pixel(px, py, r, g, b));
  endtask

  // Drop valid and wait until every predicted pixel has come out.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // One register write; valid stays high so writes can follow back to back.
  task automatic write_reg(input cfg_idx_e idx, input logic [DIM_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_WIDTH:  cur_width  = data;
      CFG_FRAME_HEIGHT: cur_height = data;
      CFG_FLASH_LEVEL:  cur_flash  = data[4:0];
      CFG_HEALTH_LEVEL: cur_health = data[3:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                                input logic [4:0] f, input logic [3:0] hl);
    wait_idle();
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_FLASH_LEVEL, DIM_W'(f));
    write_reg(CFG_HEALTH_LEVEL, DIM_W'(hl));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [CH_W-1:0] pick_channel();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 8'd0;
    if (sel == 1) return 8'd255;
    return CH_W'($urandom_range(0, 255));
  endfunction

  // Mostly inside the frame so the vignette gradient is exercised; some anywhere.
  task automatic send_random_pixel();
    int unsigned w, h;
    logic [COORD_W-1:0] px, py;
    w = dim_clamp(cur_width, MAX_WIDTH);
    h = dim_clamp(cur_height, MAX_HEIGHT);
    px = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, w - 1));
    py = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, h - 1));
    send_pixel(px, py, pick_channel(), pick_channel(), pick_channel());
  endtask

  // Random pixels in bursts; gap_max of zero means back-to-back.
  task automatic send_pixel_stream(input int count, input int gap_max);
    int burst_left;
    burst_left = $urandom_range(1, 16);
    for (int i = 0; i < count; i++) begin
      send_random_pixel();
      burst_left--;
      if (burst_left == 0 && gap_max > 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 16);
      end
    end
  endtask

  // Corner, centre and column-4095 top-row pixel under the current settings.
  task automatic send_probe_pixels();
    int unsigned cx, cy;
    cx = dim_clamp(cur_width, MAX_WIDTH) / 2;
    cy = dim_clamp(cur_height, MAX_HEIGHT) / 2;
    if (cx > 4095) cx = 4095;
    if (cy > 4095) cy = 4095;
    send_pixel(12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(cx[COORD_W-1:0], cy[COORD_W-1:0], 8'h00, 8'hFF, 8'h80);
    send_pixel(12'hFFF, 12'h000, 8'hAA, 8'h55, 8'h01);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: 256x256, no flash, health 4.
  task automatic test_reset_settings();
    send_pixel(12'd128, 12'd128, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd0, 12'd0, 8'hFF, 8'h00, 8'hFF);
    send_pixel(12'd255, 12'd255, 8'h00, 8'hFF, 8'h00);
    send_pixel(12'hFFF, 12'hFFF, 8'hFF, 8'hFF, 8'hFF);
  endtask

  // Each blend mode and the frame-size extremes, including clamped sizes.
  task automatic test_directed_modes();
    apply_settings(13'd256, 13'd256, 5'd20, 4'd4);    // strongest flash
    send_probe_pixels();
    apply_settings(13'd640, 13'd480, 5'd31, 4'd15);   // flash beyond cap
    send_probe_pixels();
    apply_settings(13'd100, 13'd60, 5'd0, 4'd1);      // red tint, health 1
    send_probe_pixels();
    apply_settings(13'd1, 13'd1, 5'd0, 4'd2);         // red tint, smallest frame
    send_probe_pixels();
    apply_settings(13'd4096, 13'd4096, 5'd5, 4'd0);   // zero health passes through
    send_probe_pixels();
    apply_settings(13'd0, 13'd8191, 5'd1, 4'd3);      // both sizes clamped
    send_probe_pixels();
  endtask

  task automatic pick_random_settings();
    logic [DIM_W-1:0] dims [2];
    logic [4:0]       f;
    logic [3:0]       hl;
    int unsigned      sel;
    for (int i = 0; i < 2; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 2)       dims[i] = 13'd1;
      else if (sel < 4)  dims[i] = 13'd4096;
      else if (sel == 4) dims[i] = 13'd0;
      else if (sel == 5) dims[i] = DIM_W'($urandom_range(4097, 8191));
      else if (sel < 10) dims[i] = DIM_W'($urandom_range(2, 64));
      else               dims[i] = DIM_W'($urandom_range(1, 4096));
    end
    sel = $urandom_range(0, 9);
    if (sel < 5)       f = 5'd0;
    else if (sel == 5) f = 5'd20;
    else if (sel == 6) f = 5'($urandom_range(21, 31));
    else               f = 5'($urandom_range(1, 19));
    sel = $urandom_range(0, 19);
    if (sel < 2)       hl = 4'd0;
    else if (sel < 9)  hl = 4'($urandom_range(1, 2));
    else               hl = 4'($urandom_range(3, 15));
    apply_settings(dims[0], dims[1], f, hl);
  endtask

  // Random settings per phase, rotating receiver patterns and sender gaps.
  task automatic test_random_phases();
    for (int phase = 0; phase < 10; phase++) begin
      pick_random_settings();
      stall_mode = phase % 3;
      send_pixel_stream(60, (phase % 4 == 0) ? 0 : $urandom_range(2, 10));
    end
  endtask

  // Receiver holds off while the sender keeps going, then the sender pauses
  // until the pipeline has drained, then a bursty receiver meets sender gaps.
  task automatic test_backpressure();
    pick_random_settings();
    stall_mode = STALL_NONE;
    hold_seq++;
    send_pixel_stream(80, 0);
    wait_idle();
    stall_mode = STALL_BURSTY;
    send_pixel_stream(48, 4);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_settings();
    test_directed_modes();
    test_random_phases();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_pixels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
